/* sv/gld_pkg.sv */
// ----------------------------------------------------------------------------
// gld_pkg: shared types and constants for the GIF LZW pixel decoder
// Holds the field widths, configuration register indexes and input modes.
// ----------------------------------------------------------------------------
package gld_pkg;

  localparam int MaxCodeBitsDef = 12;
  localparam int DictDepthDef   = 4096;
  localparam int DimBitsDef     = 16;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  typedef enum logic [2:0] {
    CFG_MIN_CODE_SIZE = 3'd0,
    CFG_IMAGE_WIDTH   = 3'd1,
    CFG_IMAGE_HEIGHT  = 3'd2,
    CFG_INTERLACED    = 3'd3,
    CFG_TRANSP_EN     = 3'd4,
    CFG_TRANSP_INDEX  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_DATA  = 2'd0,
    MODE_DRAIN = 2'd1,
    MODE_START = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  pixel_index;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic        transparent;
    logic        need_byte;
    logic        frame_done;
    logic        overrun;
    logic        format_error;
  } out_item_t;

  // Settings seen by the position unit.
  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic        interlaced;
  } geom_t;

endpackage

/* sv/gld_if.sv */
// ----------------------------------------------------------------------------
// gld_if: valid/ready channel interfaces
// Input, result and configuration channels of the decoder.
// ----------------------------------------------------------------------------
interface gld_in_if;
  import gld_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gld_out_if;
  import gld_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gld_cfg_if;
  import gld_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* sv/gld_position.sv */
// ----------------------------------------------------------------------------
// gld_position: pixel position counter
// Tracks column, row and interlace pass, stepping once per emitted pixel.
// ----------------------------------------------------------------------------
module gld_position #(
  parameter int DIM_BITS = gld_pkg::DimBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  logic                step,
  input  gld_pkg::geom_t      geom,
  output logic [DIM_BITS-1:0] column,
  output logic [DIM_BITS-1:0] row
);
  import gld_pkg::*;

  logic [DIM_BITS-1:0] col_r, row_r, w, h;
  logic [1:0]          pass_r;
  logic [DIM_BITS+3:0] r0, r1, nr;
  logic [1:0]          np;

  assign w = (geom.width[DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : geom.width[DIM_BITS-1:0];
  assign h = (geom.height[DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : geom.height[DIM_BITS-1:0];

  // Next row and pass: the pass loop has at most three short steps.
  always_comb begin
    r0 = (DIM_BITS+4)'(row_r);
    np = pass_r;
    case (pass_r)
      2'd0, 2'd1: r1 = r0 + (DIM_BITS+4)'(8);
      2'd2:       r1 = r0 + (DIM_BITS+4)'(4);
      default:    r1 = r0 + (DIM_BITS+4)'(2);
    endcase
    if (!geom.interlaced) begin
      nr = r0 + (DIM_BITS+4)'(1);
    end else begin
      nr = r1;
      if (nr >= (DIM_BITS+4)'(h) && np == 2'd0) begin np = 2'd1; nr = (DIM_BITS+4)'(4); end
      if (nr >= (DIM_BITS+4)'(h) && np == 2'd1) begin np = 2'd2; nr = (DIM_BITS+4)'(2); end
      if (nr >= (DIM_BITS+4)'(h) && np == 2'd2) begin np = 2'd3; nr = (DIM_BITS+4)'(1); end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      col_r <= '0; row_r <= '0; pass_r <= '0;
    end else if (step) begin
      if (col_r + DIM_BITS'(1) < w && col_r != '1) begin
        col_r <= col_r + DIM_BITS'(1);
      end else begin
        col_r  <= '0;
        row_r  <= nr[DIM_BITS-1:0];
        pass_r <= np;
      end
    end
  end

  assign column = col_r;
  assign row    = row_r;
endmodule

/* sv/gld_core.sv */
// ----------------------------------------------------------------------------
// gld_core: LZW code decoder around the dictionary and stack memories
// Unpacks codes, walks prefix chains in memory and pops pixels from the stack.
// ----------------------------------------------------------------------------
module gld_core #(
  parameter int MAX_CODE_BITS = gld_pkg::MaxCodeBitsDef,
  parameter int DICT_DEPTH    = gld_pkg::DictDepthDef,
  parameter int DIM_BITS      = gld_pkg::DimBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          min_code_size,
  input  logic [7:0]          transparent_index,
  input  logic                transparency_enable,
  input  gld_pkg::geom_t      geom,
  input  logic                in_valid,
  output logic                in_ready,
  input  gld_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gld_pkg::out_item_t  out_data
);
  import gld_pkg::*;

  localparam int AW = $clog2(DICT_DEPTH);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_POPW, S_DEC, S_FWALK, S_FWAIT, S_ADD, S_PWALK, S_PWAIT, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  // Memories.
  logic [AW-1:0] pre_mem [DICT_DEPTH];
  logic [7:0]    suf_mem [DICT_DEPTH];
  logic [7:0]    stk_mem [DICT_DEPTH];

  logic [23:0]   buf_r;
  logic [4:0]    cnt_r;
  logic [3:0]    cwid_r;
  logic [CW-1:0] free_r;
  logic [AW-1:0] prev_r;
  logic          aclr_r, ended_r, err_r;
  logic [CW-1:0] sp_r;
  logic [31:0]   pix_r;
  logic          ovr_r;
  logic [AW:0]   walk_r;   // current chain code (fits in AW+1 bits)
  logic [CW:0]   steps_r;
  logic [AW-1:0] code_r, old_r;
  logic          kw_r;
  logic [7:0]    fc_r;
  logic [AW-1:0] rd_pre;
  logic [7:0]    rd_suf, rd_stk;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr, mem_wr_pre;
  logic [7:0]    mem_wr_suf;
  logic          stk_wr_en;
  logic [AW-1:0] stk_wr_addr, stk_rd_addr;
  logic [7:0]    stk_wr_data;
  out_item_t     res_r;
  logic          pos_clear, pos_step;
  logic [DIM_BITS-1:0] pos_x, pos_y;

  logic [3:0]  emin;
  logic [8:0]  clr;
  logic [31:0] total;
  logic [DIM_BITS-1:0] w, h;
  logic [11:0] code_now;

  assign emin = (min_code_size < 4'd2) ? 4'd2 : (min_code_size > 4'd8) ? 4'd8 : min_code_size;
  assign clr  = 9'(1) << emin;
  assign w = (geom.width[DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : geom.width[DIM_BITS-1:0];
  assign h = (geom.height[DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : geom.height[DIM_BITS-1:0];
  assign total = 32'(w) * 32'(h);
  assign code_now = 12'(buf_r & ((24'(1) << cwid_r) - 24'(1)));

  gld_position #(.DIM_BITS(DIM_BITS)) u_pos (
    .clk(clk), .rst_n(rst_n), .clear(pos_clear), .step(pos_step),
    .geom(geom), .column(pos_x), .row(pos_y)
  );

  // Dictionary and stack memories, registered reads.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      pre_mem[mem_wr_addr] <= mem_wr_pre;
      suf_mem[mem_wr_addr] <= mem_wr_suf;
    end
    if (mem_rd_en) begin
      rd_pre <= pre_mem[mem_rd_addr];
      rd_suf <= suf_mem[mem_rd_addr];
    end
    if (stk_wr_en) stk_mem[stk_wr_addr] <= stk_wr_data;
    rd_stk <= stk_mem[stk_rd_addr];
  end

  assign stk_rd_addr = AW'(sp_r - CW'(1));

  logic walking;
  logic [AW:0] wnext;
  assign walking = (walk_r >= (AW+1)'(clr)) && (walk_r < (AW+1)'(DICT_DEPTH))
                   && (steps_r < (CW+1)'(DICT_DEPTH));

  // Memory port control.
  always_comb begin
    mem_rd_en = 1'b0; mem_rd_addr = walk_r[AW-1:0];
    mem_wr_en = 1'b0; mem_wr_addr = free_r[AW-1:0]; mem_wr_pre = prev_r; mem_wr_suf = fc_r;
    stk_wr_en = 1'b0; stk_wr_addr = sp_r[AW-1:0]; stk_wr_data = rd_suf;
    wnext = (AW+1)'(rd_pre);
    pos_clear = 1'b0; pos_step = 1'b0;
    case (state_r)
      S_FWALK: mem_rd_en = walking;
      S_PWALK: mem_rd_en = walking;
      S_ADD:   mem_wr_en = (free_r < CW'(DICT_DEPTH));
      S_PWAIT: stk_wr_en = (sp_r < CW'(DICT_DEPTH));
      S_IDLE:  pos_clear = in_valid && (in_data.mode == MODE_START);
      S_POPW:  pos_step = (pix_r < total);
      default: ;
    endcase
    if (state_r == S_PWALK && !walking) begin
      stk_wr_en = (sp_r < CW'(DICT_DEPTH)); stk_wr_data = walk_r[7:0];
    end
    if (state_r == S_DEC && aclr_r && code_now < 12'(clr)) begin
      stk_wr_en = 1'b1; stk_wr_data = code_now[7:0];
    end
    // The KwKwK leading pixel goes on the stack as the entry is added.
    if (state_r == S_ADD && kw_r) begin
      stk_wr_en = (sp_r < CW'(DICT_DEPTH)); stk_wr_data = fc_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      buf_r <= '0; cnt_r <= '0; cwid_r <= 4'd9; free_r <= CW'(258);
      prev_r <= '0; aclr_r <= 1'b1; ended_r <= 1'b0; err_r <= 1'b0;
      sp_r <= '0; pix_r <= '0; ovr_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ovr_r <= 1'b0;
            res_r <= '0;
            if (in_data.mode == MODE_START) begin
              buf_r <= '0; cnt_r <= '0; cwid_r <= emin + 4'd1;
              free_r <= CW'(clr) + CW'(2); aclr_r <= 1'b1; prev_r <= '0;
              sp_r <= '0; pix_r <= '0; err_r <= 1'b0; ended_r <= 1'b0;
              state_r <= S_FIN;
            end else begin
              if (in_data.mode == MODE_DATA) begin
                if (sp_r == '0 && !ended_r && cnt_r < 5'(cwid_r)) begin
                  buf_r <= buf_r | (24'(in_data.data_byte) << cnt_r);
                  cnt_r <= cnt_r + 5'd8;
                end else begin
                  ovr_r <= 1'b1;
                end
              end
              state_r <= S_POP;
            end
          end
        end
        S_POP: begin
          if (sp_r == '0 && !ended_r && cnt_r >= 5'(cwid_r)) state_r <= S_DEC;
          else if (sp_r != '0) state_r <= S_POPW;
          else state_r <= S_FIN;
        end
        // One code per request: codes that push nothing finish the request.
        S_DEC: begin
          buf_r <= buf_r >> cwid_r;
          cnt_r <= cnt_r - 5'(cwid_r);
          code_r <= AW'(code_now);
          if (code_now == 12'(clr)) begin
            cwid_r <= emin + 4'd1; free_r <= CW'(clr) + CW'(2); aclr_r <= 1'b1;
            state_r <= S_FIN;
          end else if (code_now == 12'(clr) + 12'd1) begin
            ended_r <= 1'b1;
            if (pix_r != total) err_r <= 1'b1;
            state_r <= S_FIN;
          end else if (aclr_r) begin
            if (code_now >= 12'(clr)) begin
              err_r <= 1'b1;
              state_r <= S_FIN;
            end else begin
              sp_r <= sp_r + CW'(1); prev_r <= AW'(code_now); aclr_r <= 1'b0;
              state_r <= S_POP;
            end
          end else begin
            kw_r <= (CW'(code_now) >= free_r);
            old_r <= prev_r;
            walk_r <= (CW'(code_now) >= free_r) ? (AW+1)'(prev_r) : (AW+1)'(code_now);
            steps_r <= '0;
            state_r <= S_FWALK;
          end
        end
        S_FWALK: begin
          if (walking) state_r <= S_FWAIT;
          else begin fc_r <= walk_r[7:0]; state_r <= S_ADD; end
        end
        S_FWAIT: begin
          walk_r <= wnext; steps_r <= steps_r + (CW+1)'(1); state_r <= S_FWALK;
        end
        S_ADD: begin
          if (free_r < CW'(DICT_DEPTH)) begin
            free_r <= free_r + CW'(1);
            if (kw_r) prev_r <= free_r[AW-1:0];
          end
          if (!kw_r) prev_r <= code_r;
          if (kw_r) begin
            if (sp_r < CW'(DICT_DEPTH)) sp_r <= sp_r + CW'(1);
            walk_r <= (AW+1)'(old_r);
          end else walk_r <= (AW+1)'(code_r);
          steps_r <= '0;
          state_r <= S_PWALK;
        end
        S_PWALK: begin
          if (walking) state_r <= S_PWAIT;
          else begin
            if (sp_r < CW'(DICT_DEPTH)) sp_r <= sp_r + CW'(1);
            if (free_r >= (CW'(1) << cwid_r) && cwid_r < 4'(MAX_CODE_BITS))
              cwid_r <= cwid_r + 4'd1;
            state_r <= S_POP;
          end
        end
        S_PWAIT: begin
          if (sp_r < CW'(DICT_DEPTH)) sp_r <= sp_r + CW'(1);
          walk_r <= wnext; steps_r <= steps_r + (CW+1)'(1); state_r <= S_PWALK;
        end
        S_POPW: begin
          sp_r <= sp_r - CW'(1);
          if (pix_r >= total) err_r <= 1'b1;
          else begin
            res_r.pixel_valid <= 1'b1;
            res_r.pixel_index <= rd_stk;
            res_r.pixel_x <= 16'(pos_x);
            res_r.pixel_y <= 16'(pos_y);
            res_r.transparent <= transparency_enable && (rd_stk == transparent_index);
            pix_r <= pix_r + 32'd1;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          res_r.need_byte <= (sp_r == '0) && !ended_r && (cnt_r < 5'(cwid_r));
          res_r.frame_done <= ended_r && (pix_r == total);
          res_r.overrun <= ovr_r;
          res_r.format_error <= err_r;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/gld_regs.sv */
// ----------------------------------------------------------------------------
// gld_regs: configuration register file
// Holds the six decoder settings written through the configuration channel.
// ----------------------------------------------------------------------------
module gld_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [gld_pkg::CfgIdxBits-1:0]  wr_index,
  input  logic [gld_pkg::CfgDataBits-1:0] wr_data,
  output logic [3:0]                      min_code_size,
  output logic [7:0]                      transparent_index,
  output logic                            transparency_enable,
  output gld_pkg::geom_t                  geom
);
  import gld_pkg::*;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_code_size <= 4'd8; geom <= '{16'd1, 16'd1, 1'b0};
      transparency_enable <= 1'b0; transparent_index <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MIN_CODE_SIZE: min_code_size <= wr_data[3:0];
        CFG_IMAGE_WIDTH:   geom.width <= wr_data;
        CFG_IMAGE_HEIGHT:  geom.height <= wr_data;
        CFG_INTERLACED:    geom.interlaced <= wr_data[0];
        CFG_TRANSP_EN:     transparency_enable <= wr_data[0];
        CFG_TRANSP_INDEX:  transparent_index <= wr_data[7:0];
        default: ;
      endcase
    end
  end
endmodule

/* sv/gif_lzw_pixel_decoder.sv */
// Each accepted request gives one result and pops at most one pixel; a table code walks
// its prefix chain twice before the pop (once for the first pixel, once to push the chain).
// Throughput: one request at a time, the next taken the cycle after the result goes out.
// Reset: synchronous active-low rst_n restores configuration defaults and decoder
// state; dictionary and stack memories are not cleared.
// ----------------------------------------------------------------------------
// gif_lzw_pixel_decoder: GIF LZW decoder top level
// Connects the configuration registers and the memory-based decoder core.
// ----------------------------------------------------------------------------
module gif_lzw_pixel_decoder #(
  parameter int MAX_CODE_BITS = gld_pkg::MaxCodeBitsDef,
  parameter int DICT_DEPTH    = gld_pkg::DictDepthDef,
  parameter int DIM_BITS      = gld_pkg::DimBitsDef
) (
  input logic   clk,
  input logic   rst_n,
  gld_in_if.sink    in_ch,
  gld_out_if.source out_ch,
  gld_cfg_if.sink   cfg_ch
);
  import gld_pkg::*;

  logic [3:0] min_code_size;
  logic [7:0] transparent_index;
  logic       transparency_enable;
  geom_t      geom;

  assign cfg_ch.ready = 1'b1;

  gld_regs u_regs (
    .clk(clk), .rst_n(rst_n), .wr_en(cfg_ch.valid), .wr_index(cfg_ch.index),
    .wr_data(cfg_ch.wdata), .min_code_size(min_code_size),
    .transparent_index(transparent_index), .transparency_enable(transparency_enable),
    .geom(geom)
  );

  gld_core #(.MAX_CODE_BITS(MAX_CODE_BITS), .DICT_DEPTH(DICT_DEPTH), .DIM_BITS(DIM_BITS))
  u_core (
    .clk(clk), .rst_n(rst_n), .min_code_size(min_code_size),
    .transparent_index(transparent_index), .transparency_enable(transparency_enable),
    .geom(geom), .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule
